// File: hdl/grt_pkg.sv
`default_nettype none

package grt_pkg;

  localparam int unsigned CAP_BYTES = 12;
  localparam logic [6:0] COUNT_MAX = 7'd127;

  // report ids
  localparam logic [7:0] RID_FULL_ZERO = 8'h00;
  localparam logic [7:0] RID_FULL      = 8'h30;
  localparam logic [7:0] RID_SIMPLE    = 8'h3f;
  localparam logic [7:0] RID_STREAM    = 8'h21;
  localparam logic [7:0] RID_STATUS    = 8'h81;

  // status bytes and host command codes
  localparam logic [7:0] STATUS_01       = 8'h01;
  localparam logic [7:0] STATUS_02       = 8'h02;
  localparam logic [7:0] CMD_CODE_ACK    = 8'h02;
  localparam logic [7:0] CMD_CODE_STREAM = 8'h04;

  // handshake phases
  localparam logic [1:0] PH_WAIT01 = 2'd0;
  localparam logic [1:0] PH_WAIT02 = 2'd1;
  localparam logic [1:0] PH_STREAM = 2'd2;

  // v * 255 / 4095 == v * 17 / 273, done as a reciprocal multiply
  localparam logic [16:0] SCALE_MUL = 17'd122911;

  localparam logic [2:0] BURST_LAST = 3'd4;

  typedef enum logic [1:0] {
    KIND_PAD  = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_DESC = 2'd2
  } grt_kind_e;

  typedef enum logic [1:0] {
    OP_PAD   = 2'd0,
    OP_CMD   = 2'd1,
    OP_BURST = 2'd2
  } grt_op_e;

  typedef struct packed {
    grt_op_e     op;
    logic [17:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  l2_level;
    logic [7:0]  r2_level;
    logic [7:0]  code;
    logic [3:0]  seq;
  } grt_entry_t;

  function automatic logic [7:0] scale12(input logic [11:0] v);
    logic [16:0] x;
    logic [33:0] p;
    x = {1'b0, v, 4'b0000} + {5'b00000, v};
    p = 34'(x) * 34'(SCALE_MUL);
    return p[32:25];
  endfunction

  // face, shoulder and system buttons
  function automatic logic [13:0] common_bits(input logic [7:0] r, input logic [7:0] s,
                                               input logic [7:0] l);
    return {s[5], s[4], s[0], s[1], s[2], s[3], r[7], r[6], l[7], l[6],
            r[1], r[0], r[3], r[2]};
  endfunction

  // returns {left, right, down, up}
  function automatic logic [3:0] hat_bits(input logic [7:0] hat);
    logic [3:0] b;
    case (hat)
      8'd0: b = 4'b0001;
      8'd1: b = 4'b0101;
      8'd2: b = 4'b0100;
      8'd3: b = 4'b0110;
      8'd4: b = 4'b0010;
      8'd5: b = 4'b1010;
      8'd6: b = 4'b1000;
      8'd7: b = 4'b1001;
      default: b = 4'b0000;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] desc_code(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = 8'h40;
      2'd1: c = 8'h48;
      2'd2: c = 8'h30;
      2'd3: c = 8'h03;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] desc_arg(input logic [1:0] idx);
    return (idx == 2'd3) ? 8'h30 : 8'h01;
  endfunction

endpackage

`default_nettype wire

// File: hdl/grt_front.sv
`default_nettype none

module grt_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               end_of_packet_i,
  input  wire logic               queue_ready_i,
  output logic                    push_o,
  output grt_pkg::grt_entry_t     entry_o
);
  import grt_pkg::*;

  logic             accept;
  logic [7:0]       cap_q [CAP_BYTES];
  logic [7:0]       bv [CAP_BYTES];
  logic [6:0]       count_q, count_d;
  logic [1:0]       phase_q, phase_d;
  logic [3:0]       seq_q, seq_d;
  logic [7:0]       stick_q [4];
  logic [7:0]       sv [4];
  logic [11:0]      sc_in;
  logic [7:0]       sc_out;
  logic             sc_hit;
  logic [1:0]       sc_sel;
  logic [7:0]       rid;
  logic [7:0]       sub;
  logic             long_full;
  logic             long_simple;
  grt_entry_t       full_e;
  grt_entry_t       simple_e;
  grt_entry_t       entry;
  logic             push;

  assign in_ready_o = queue_ready_i;
  assign accept     = in_valid_i & queue_ready_i;

  // packet bytes as seen with the incoming byte in place
  always_comb begin
    for (int i = 0; i < CAP_BYTES; i++) begin
      bv[i] = (count_q == 7'(i)) ? rx_byte_i : cap_q[i];
    end
  end

  // one shared scaler, used as each stick's last byte arrives
  always_comb begin
    sc_hit = 1'b1;
    sc_sel = 2'd0;
    sc_in  = {rx_byte_i[3:0], cap_q[6]};
    case (count_q)
      7'd7: begin
        sc_sel = 2'd0;
        sc_in  = {rx_byte_i[3:0], cap_q[6]};
      end
      7'd8: begin
        sc_sel = 2'd1;
        sc_in  = {rx_byte_i, cap_q[7][7:4]};
      end
      7'd10: begin
        sc_sel = 2'd2;
        sc_in  = {rx_byte_i[3:0], cap_q[9]};
      end
      7'd11: begin
        sc_sel = 2'd3;
        sc_in  = {rx_byte_i, cap_q[10][7:4]};
      end
      default: begin
        sc_hit = 1'b0;
      end
    endcase
  end

  assign sc_out = scale12(sc_in);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sv[j] = (sc_hit && (sc_sel == 2'(j))) ? sc_out : stick_q[j];
    end
  end

  always_comb begin
    full_e          = '0;
    full_e.op       = OP_PAD;
    full_e.buttons  = {bv[5][3], bv[5][2], bv[5][0], bv[5][1],
                       common_bits(bv[3], bv[4], bv[5])};
    full_e.left_x   = sv[0];
    full_e.left_y   = sv[1];
    full_e.right_x  = sv[2];
    full_e.right_y  = sv[3];
    full_e.l2_level = bv[5][7] ? 8'hff : 8'h00;
    full_e.r2_level = bv[3][7] ? 8'hff : 8'h00;

    simple_e          = '0;
    simple_e.op       = OP_PAD;
    simple_e.buttons  = {hat_bits(bv[3]), common_bits(bv[1], bv[2], bv[8])};
    simple_e.left_x   = bv[4];
    simple_e.left_y   = bv[5];
    simple_e.right_x  = bv[6];
    simple_e.right_y  = bv[7];
    simple_e.l2_level = bv[8][7] ? 8'hff : 8'h00;
    simple_e.r2_level = bv[1][7] ? 8'hff : 8'h00;
  end

  assign rid         = bv[0];
  assign long_full   = count_q >= 7'd11;
  assign long_simple = count_q >= 7'd8;
  assign sub         = (count_q != 7'd0) ? bv[1] : 8'h00;

  // classify the packet on its last byte
  always_comb begin
    push    = 1'b0;
    entry   = '0;
    phase_d = phase_q;
    seq_d   = seq_q;
    if (accept && end_of_packet_i) begin
      case (rid)
        RID_FULL_ZERO, RID_FULL: begin
          if (long_full && !((rid == RID_FULL_ZERO) && (bv[1] == 8'h00))) begin
            phase_d = PH_STREAM;
            push    = 1'b1;
            entry   = full_e;
          end
        end
        RID_SIMPLE: begin
          if (long_simple) begin
            push  = 1'b1;
            entry = simple_e;
          end
        end
        RID_STREAM: begin
          if (long_full && (phase_q == PH_STREAM)) begin
            push  = 1'b1;
            entry = full_e;
          end
        end
        RID_STATUS: begin
          if (phase_q == PH_STREAM) begin
            phase_d = PH_WAIT01;
          end else if ((sub == STATUS_01) && (phase_q == PH_WAIT01)) begin
            push       = 1'b1;
            entry.op   = OP_CMD;
            entry.code = CMD_CODE_ACK;
            phase_d    = PH_WAIT02;
          end else if (sub == STATUS_02) begin
            push      = 1'b1;
            entry.op  = OP_BURST;
            entry.seq = seq_q;
            seq_d     = seq_q + 4'd4;
            phase_d   = PH_STREAM;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (end_of_packet_i) begin
        count_d = 7'd0;
      end else if (count_q != COUNT_MAX) begin
        count_d = count_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 7'd0;
      phase_q <= PH_WAIT01;
      seq_q   <= 4'd0;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
      seq_q   <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (count_q < 7'(CAP_BYTES))) begin
      cap_q[count_q[3:0]] <= rx_byte_i;
    end
    if (accept && sc_hit) begin
      stick_q[sc_sel] <= sc_out;
    end
  end

  assign push_o  = push;
  assign entry_o = entry;

endmodule

`default_nettype wire

// File: hdl/grt_queue.sv
`default_nettype none

module grt_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  grt_pkg::grt_entry_t     entry_i,
  output logic                    ready_o,
  output logic                    valid_o,
  output grt_pkg::grt_entry_t     entry_o,
  input  wire logic               pop_i
);
  import grt_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  grt_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign ready_o = cnt_q != CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: hdl/grt_back.sv
`default_nettype none

module grt_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  grt_pkg::grt_entry_t     head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              result_kind_o,
  output logic [17:0]             buttons_o,
  output logic [7:0]              left_x_o,
  output logic [7:0]              left_y_o,
  output logic [7:0]              right_x_o,
  output logic [7:0]              right_y_o,
  output logic [7:0]              l2_level_o,
  output logic [7:0]              r2_level_o,
  output logic [7:0]              code_o,
  output logic [7:0]              arg_o,
  output logic [3:0]              seq_no_o,
  output logic                    last_o
);
  import grt_pkg::*;

  typedef struct packed {
    grt_kind_e   kind;
    logic [17:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  l2_level;
    logic [7:0]  r2_level;
    logic [7:0]  code;
    logic [7:0]  arg;
    logic [3:0]  seq;
    logic        last;
  } grt_result_t;

  logic        out_valid_q;
  grt_result_t res_q, res_d;
  logic [2:0]  idx_q, idx_d;
  logic [1:0]  d_idx;
  logic        load;
  logic        entry_last;

  assign load       = head_valid_i && (!out_valid_q || out_ready_i);
  assign entry_last = (head_i.op != OP_BURST) || (idx_q == BURST_LAST);
  assign pop_o      = load && entry_last;
  assign d_idx      = 2'(idx_q - 3'd1);

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = entry_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_comb begin
    res_d = '0;
    case (head_i.op)
      OP_PAD: begin
        res_d.kind     = KIND_PAD;
        res_d.buttons  = head_i.buttons;
        res_d.left_x   = head_i.left_x;
        res_d.left_y   = head_i.left_y;
        res_d.right_x  = head_i.right_x;
        res_d.right_y  = head_i.right_y;
        res_d.l2_level = head_i.l2_level;
        res_d.r2_level = head_i.r2_level;
        res_d.last     = 1'b1;
      end
      OP_CMD: begin
        res_d.kind = KIND_CMD;
        res_d.code = head_i.code;
        res_d.last = 1'b1;
      end
      OP_BURST: begin
        if (idx_q == 3'd0) begin
          res_d.kind = KIND_CMD;
          res_d.code = CMD_CODE_STREAM;
        end else begin
          res_d.kind = KIND_DESC;
          res_d.code = desc_code(d_idx);
          res_d.arg  = desc_arg(d_idx);
          res_d.seq  = head_i.seq + {2'b00, d_idx};
          res_d.last = idx_q == BURST_LAST;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = res_q.kind;
  assign buttons_o     = res_q.buttons;
  assign left_x_o      = res_q.left_x;
  assign left_y_o      = res_q.left_y;
  assign right_x_o     = res_q.right_x;
  assign right_y_o     = res_q.right_y;
  assign l2_level_o    = res_q.l2_level;
  assign r2_level_o    = res_q.r2_level;
  assign code_o        = res_q.code;
  assign arg_o         = res_q.arg;
  assign seq_no_o      = res_q.seq;
  assign last_o        = res_q.last;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= BURST_LAST) else $error("burst index out of range");

  a_idx_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 3'd0) |-> (head_valid_i && (head_i.op == OP_BURST)))
    else $error("burst in progress without burst entry at head");

  a_stream_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.kind == KIND_CMD) && (res_q.code == CMD_CODE_STREAM))
      |-> !res_q.last) else $error("stream command marked last");

endmodule

`default_nettype wire

// File: hdl/gamepad_report_translator.sv
// Controller report translator.
// Input channel (in_valid_i/in_ready_o): one packet byte per transfer on rx_byte_i,
// end_of_packet_i high on the last byte. A byte per cycle while in_ready_o is high.
// Output channel (out_valid_o/out_ready_i): one result per transfer, last_o high
// on the final result of a packet. A pad report gives one pad update (stream
// reports only while streaming), an awaited status 01 one host command, a status
// 02 outside streaming a host command and four subcommand descriptors; others none.
// After the transfer of its last byte, the first result of a packet is written
// into the queue, then into the output register. Results leave at one per cycle
// while out_ready_i is high; the output register reloads in the cycle it is taken.
// The classifier posts one entry per producing packet into a QUEUE_DEPTH queue;
// in_ready_o drops only while that queue is full: under a long output stall, or
// under a run of short status packets whose five-result bursts drain slower than
// their bytes arrive.
// Reset: byte count and queue empty, handshake waits for status 01, sequence
// counter at zero. Stalling the output holds the current result unchanged.
`default_nettype none

module gamepad_report_translator #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        end_of_packet_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [17:0]      buttons_o,
  output logic [7:0]       left_x_o,
  output logic [7:0]       left_y_o,
  output logic [7:0]       right_x_o,
  output logic [7:0]       right_y_o,
  output logic [7:0]       l2_level_o,
  output logic [7:0]       r2_level_o,
  output logic [7:0]       code_o,
  output logic [7:0]       arg_o,
  output logic [3:0]       seq_no_o,
  output logic             last_o
);
  import grt_pkg::*;

  logic       push;
  logic       queue_ready;
  logic       head_valid;
  logic       pop;
  grt_entry_t push_entry;
  grt_entry_t head_entry;

  grt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .queue_ready_i   (queue_ready),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  grt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (queue_ready),
    .valid_o (head_valid),
    .entry_o (head_entry),
    .pop_i   (pop)
  );

  grt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .buttons_o     (buttons_o),
    .left_x_o      (left_x_o),
    .left_y_o      (left_y_o),
    .right_x_o     (right_x_o),
    .right_y_o     (right_y_o),
    .l2_level_o    (l2_level_o),
    .r2_level_o    (r2_level_o),
    .code_o        (code_o),
    .arg_o         (arg_o),
    .seq_no_o      (seq_no_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import grt_pkg::*;

  localparam int unsigned FULL_LEN = 12;
  localparam int unsigned SIMPLE_LEN = 9;
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned RANDOM_ITEMS = 290;
  localparam int unsigned LONG_PKT_LEN = 130;
  localparam int unsigned TAIL_ITEMS = 60;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned HOLD_OFF_AFTER = 30;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned TIMEOUT_NS = 1_000_000;

  localparam logic [7:0] RID_UNKNOWN = 8'h55;
  localparam logic [7:0] STATUS_OTHER = 8'h03;
  localparam logic [0:3][7:0] SUBCMD_CODE = {8'h40, 8'h48, 8'h30, 8'h03};
  localparam logic [0:3][7:0] SUBCMD_ARG = {8'h01, 8'h01, 8'h01, 8'h30};

  // d-pad as {left, right, down, up}
  localparam logic [3:0] DP_UP = 4'b0001;
  localparam logic [3:0] DP_DOWN = 4'b0010;
  localparam logic [3:0] DP_RIGHT = 4'b0100;
  localparam logic [3:0] DP_LEFT = 4'b1000;

  typedef struct packed {
    grt_kind_e   kind;
    logic [17:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  l2_level;
    logic [7:0]  r2_level;
    logic [7:0]  code;
    logic [7:0]  arg;
    logic [3:0]  seq_no;
    logic        last;
  } pad_result_t;

  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_ONE   = 2'd2
  } row_check_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        eop;
    row_check_e  chk;
    pad_result_t res;
  } stim_item_t;

  typedef struct {
    logic [0:11][7:0] data;
    int unsigned      len;
    row_check_e       chk;
    pad_result_t      res;
  } pkt_row_t;

  localparam pad_result_t NO_RESULT = '0;
  localparam pad_result_t ACK_RESULT =
    {KIND_CMD, 18'h0, 48'h0, CMD_CODE_ACK, 8'h00, 4'h0, 1'b1};
  localparam pad_result_t PAD_ALL_ONES =
    {KIND_PAD, 18'h3ffff, 48'hffff_ffff_ffff, 8'h00, 8'h00, 4'h0, 1'b1};
  localparam pad_result_t PAD_ALL_ZERO =
    {KIND_PAD, 18'h0, 48'h0, 8'h00, 8'h00, 4'h0, 1'b1};

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        end_of_packet_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  result_kind_o;
  logic [17:0] buttons_o;
  logic [7:0]  left_x_o;
  logic [7:0]  left_y_o;
  logic [7:0]  right_x_o;
  logic [7:0]  right_y_o;
  logic [7:0]  l2_level_o;
  logic [7:0]  r2_level_o;
  logic [7:0]  code_o;
  logic [7:0]  arg_o;
  logic [3:0]  seq_no_o;
  logic        last_o;

  gamepad_report_translator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .buttons_o      (buttons_o),
    .left_x_o       (left_x_o),
    .left_y_o       (left_y_o),
    .right_x_o      (right_x_o),
    .right_y_o      (right_y_o),
    .l2_level_o     (l2_level_o),
    .r2_level_o     (r2_level_o),
    .code_o         (code_o),
    .arg_o          (arg_o),
    .seq_no_o       (seq_no_o),
    .last_o         (last_o)
  );

  // translator state as seen from the byte stream
  logic [7:0]  cap_bytes [CAP_BYTES];
  logic [6:0]  rx_count;
  logic [1:0]  hs_phase;
  logic [3:0]  subcmd_seq;
  pad_result_t report_out [MAX_RESULTS];

  pad_result_t pending_results_q [$];
  stim_item_t  byte_stream_q [$];
  stim_item_t  cur_item;
  int unsigned fail_cnt;
  int unsigned taken_cnt;
  bit          calm_tail;
  bit          stim_done;

  function automatic logic [7:0] stick_8bit(input logic [11:0] raw);
    int unsigned v;
    v = raw;
    return 8'((v * 255) / 4095);
  endfunction

  function automatic pad_result_t pad_update(input logic [7:0] r, input logic [7:0] s,
                                             input logic [7:0] l, input logic [3:0] dpad,
                                             input logic [0:3][7:0] stick);
    pad_result_t p;
    p = '0;
    p.kind = KIND_PAD;
    p.buttons[0] = r[2];
    p.buttons[1] = r[3];
    p.buttons[2] = r[0];
    p.buttons[3] = r[1];
    p.buttons[4] = l[6];
    p.buttons[5] = l[7];
    p.buttons[6] = r[6];
    p.buttons[7] = r[7];
    p.buttons[8] = s[3];
    p.buttons[9] = s[2];
    p.buttons[10] = s[1];
    p.buttons[11] = s[0];
    p.buttons[12] = s[4];
    p.buttons[13] = s[5];
    p.buttons[17:14] = dpad;
    p.left_x = stick[0];
    p.left_y = stick[1];
    p.right_x = stick[2];
    p.right_y = stick[3];
    p.l2_level = l[7] ? 8'hff : 8'h00;
    p.r2_level = r[7] ? 8'hff : 8'h00;
    return p;
  endfunction

  function automatic pad_result_t full_update();
    logic [0:3][7:0] stick;
    logic [7:0] l;
    l = cap_bytes[5];
    stick[0] = stick_8bit({cap_bytes[7][3:0], cap_bytes[6]});
    stick[1] = stick_8bit({cap_bytes[8], cap_bytes[7][7:4]});
    stick[2] = stick_8bit({cap_bytes[10][3:0], cap_bytes[9]});
    stick[3] = stick_8bit({cap_bytes[11], cap_bytes[10][7:4]});
    return pad_update(cap_bytes[3], cap_bytes[4], l, {l[3], l[2], l[0], l[1]}, stick);
  endfunction

  function automatic pad_result_t host_cmd(input logic [7:0] code);
    pad_result_t p;
    p = '0;
    p.kind = KIND_CMD;
    p.code = code;
    return p;
  endfunction

  // one accepted byte; returns how many results it causes, in report_out
  function automatic int translate_byte(input logic [7:0] b, input logic eop);
    int unsigned len;
    logic [7:0] rid;
    logic [7:0] status;
    logic [3:0] dpad;
    int n;
    if (rx_count < CAP_BYTES) cap_bytes[rx_count] = b;
    if (rx_count != COUNT_MAX) rx_count = rx_count + 7'd1;
    if (!eop) return 0;
    len = rx_count;
    rx_count = '0;
    rid = cap_bytes[0];
    n = 0;
    if (rid == RID_FULL_ZERO || rid == RID_FULL) begin
      if (len >= FULL_LEN && !(rid == RID_FULL_ZERO && cap_bytes[1] == 8'h00)) begin
        hs_phase = PH_STREAM;
        report_out[0] = full_update();
        n = 1;
      end
    end else if (rid == RID_SIMPLE) begin
      if (len >= SIMPLE_LEN) begin
        case (cap_bytes[3])
          8'd0: dpad = DP_UP;
          8'd1: dpad = DP_UP | DP_RIGHT;
          8'd2: dpad = DP_RIGHT;
          8'd3: dpad = DP_DOWN | DP_RIGHT;
          8'd4: dpad = DP_DOWN;
          8'd5: dpad = DP_DOWN | DP_LEFT;
          8'd6: dpad = DP_LEFT;
          8'd7: dpad = DP_UP | DP_LEFT;
          default: dpad = 4'b0000;
        endcase
        report_out[0] = pad_update(cap_bytes[1], cap_bytes[2], cap_bytes[8], dpad,
                                   {cap_bytes[4], cap_bytes[5], cap_bytes[6], cap_bytes[7]});
        n = 1;
      end
    end else if (rid == RID_STREAM) begin
      if (len >= FULL_LEN && hs_phase == PH_STREAM) begin
        report_out[0] = full_update();
        n = 1;
      end
    end else if (rid == RID_STATUS) begin
      status = (len >= 2) ? cap_bytes[1] : 8'h00;
      if (hs_phase == PH_STREAM) begin
        hs_phase = PH_WAIT01;
      end else if (status == STATUS_01 && hs_phase == PH_WAIT01) begin
        report_out[0] = host_cmd(CMD_CODE_ACK);
        hs_phase = PH_WAIT02;
        n = 1;
      end else if (status == STATUS_02) begin
        report_out[0] = host_cmd(CMD_CODE_STREAM);
        for (int i = 0; i < 4; i++) begin
          report_out[i + 1] = '0;
          report_out[i + 1].kind = KIND_DESC;
          report_out[i + 1].code = SUBCMD_CODE[i];
          report_out[i + 1].arg = SUBCMD_ARG[i];
          report_out[i + 1].seq_no = subcmd_seq;
          subcmd_seq = subcmd_seq + 4'd1;
        end
        hs_phase = PH_STREAM;
        n = 5;
      end
    end
    if (n > 0) report_out[n - 1].last = 1'b1;
    return n;
  endfunction

  function automatic string show(input pad_result_t p);
    return $sformatf({"kind=%0d btn=%05h sticks=%02h/%02h/%02h/%02h lvl=%02h/%02h",
                      " code=%02h arg=%02h seq=%0d last=%0d"},
                     p.kind, p.buttons, p.left_x, p.left_y, p.right_x, p.right_y,
                     p.l2_level, p.r2_level, p.code, p.arg, p.seq_no, p.last);
  endfunction

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("%t %s", $realtime, msg);
  endfunction

  function automatic pkt_row_t dir_row(input logic [0:11][7:0] data, input int unsigned len,
                                       input row_check_e chk, input pad_result_t res);
    pkt_row_t r;
    r.data = data;
    r.len = len;
    r.chk = chk;
    r.res = res;
    return r;
  endfunction

  task automatic queue_packet(input logic [0:11][7:0] data, input int unsigned len,
                              input row_check_e chk, input pad_result_t res);
    stim_item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it.data_byte = (i < FULL_LEN) ? data[i] : 8'($urandom);
      it.eop = (i == len - 1);
      it.chk = it.eop ? chk : CHK_MODEL;
      it.res = res;
      byte_stream_q.push_back(it);
    end
  endtask

  task automatic add_random_packets(input int unsigned target);
    logic [0:11][7:0] d;
    int unsigned len;
    int unsigned sel;
    int unsigned pick;
    int unsigned start;
    bit long_done;
    start = byte_stream_q.size();
    long_done = 0;
    while (byte_stream_q.size() < start + target) begin
      d = {$urandom, $urandom, $urandom};
      sel = $urandom_range(0, 99);
      len = FULL_LEN;
      if (!long_done && byte_stream_q.size() > start + 150) begin
        long_done = 1;
        d[0] = RID_FULL;
        len = LONG_PKT_LEN;
      end else if (sel < 22) begin
        d[0] = RID_STATUS;
        d[1] = (sel < 12) ? STATUS_01 : STATUS_02;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 6) : 2;
      end else if (sel < 52) begin
        pick = $urandom_range(0, 19);
        d[0] = (pick < 10) ? RID_STREAM : (pick < 17) ? RID_FULL : RID_FULL_ZERO;
        if (d[0] == RID_FULL_ZERO && $urandom_range(0, 2) == 0) d[1] = 8'h00;
        if ($urandom_range(0, 4) == 0) len = $urandom_range(13, 16);
      end else if (sel < 76) begin
        d[0] = RID_SIMPLE;
        d[3] = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 8)) : 8'($urandom);
        len = $urandom_range(SIMPLE_LEN, FULL_LEN);
      end else if (sel < 86) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0: begin
            d[0] = $urandom_range(0, 1) ? RID_FULL : RID_STREAM;
            len = $urandom_range(1, FULL_LEN - 1);
          end
          1: begin
            d[0] = RID_SIMPLE;
            len = $urandom_range(1, SIMPLE_LEN - 1);
          end
          2: begin
            d[0] = RID_STATUS;
            len = 1;
          end
          default: begin
            d[0] = RID_FULL_ZERO;
            len = $urandom_range(1, FULL_LEN - 1);
          end
        endcase
      end else begin
        len = $urandom_range(1, 14);
      end
      queue_packet(d, len, CHK_MODEL, NO_RESULT);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin : sender
    pkt_row_t dir_rows [$];
    stim_item_t it;
    in_valid_i = 1'b0;
    rx_byte_i = 8'h00;
    end_of_packet_i = 1'b0;
    calm_tail = 0;
    stim_done = 0;

    dir_rows.push_back(dir_row({RID_STATUS, STATUS_01, 80'h0}, 2, CHK_ONE, ACK_RESULT));
    // one-byte status reads as status 0
    dir_rows.push_back(dir_row({RID_STATUS, 88'h0}, 1, CHK_NONE, NO_RESULT));
    dir_rows.push_back(dir_row({RID_STATUS, STATUS_01, 80'h0}, 2, CHK_NONE, NO_RESULT));
    dir_rows.push_back(dir_row({RID_STATUS, STATUS_02, 80'h0}, 2, CHK_MODEL, NO_RESULT));
    dir_rows.push_back(dir_row({RID_STREAM, {11{8'hff}}}, 12, CHK_ONE, PAD_ALL_ONES));
    dir_rows.push_back(dir_row({RID_FULL, 88'h0}, 12, CHK_ONE, PAD_ALL_ZERO));
    // all-zero artifact
    dir_rows.push_back(dir_row({RID_FULL_ZERO, 88'h0}, 12, CHK_NONE, NO_RESULT));
    dir_rows.push_back(dir_row({RID_FULL_ZERO, 88'h01_a5_3c_c3_12_f0_0f_80_7f_00_ff}, 12,
                               CHK_MODEL, NO_RESULT));
    dir_rows.push_back(dir_row({RID_FULL, 88'h11_22_33_44_55_66_77_88_99_aa_bb}, 11,
                               CHK_NONE, NO_RESULT));
    dir_rows.push_back(dir_row({RID_SIMPLE, 88'hc5_3a_03_00_ff_80_7f_40_00_00_00}, 9,
                               CHK_MODEL, NO_RESULT));
    dir_rows.push_back(dir_row({RID_SIMPLE, 88'h3a_c5_08_01_fe_5a_a5_bf_00_00_00}, 10,
                               CHK_MODEL, NO_RESULT));
    dir_rows.push_back(dir_row({RID_SIMPLE, 88'hff_ff_02_10_20_30_40_00_00_00_00}, 8,
                               CHK_NONE, NO_RESULT));
    // status while streaming drops back to waiting
    dir_rows.push_back(dir_row({RID_STATUS, STATUS_02, 80'h0}, 2, CHK_NONE, NO_RESULT));
    dir_rows.push_back(dir_row({RID_STREAM, 88'h01_ff_ff_ff_ff_ff_ff_ff_ff_ff_ff}, 12,
                               CHK_NONE, NO_RESULT));
    dir_rows.push_back(dir_row({RID_UNKNOWN, 88'h01_02_03_04_05_06_07_08_09_0a_0b}, 5,
                               CHK_NONE, NO_RESULT));
    dir_rows.push_back(dir_row({RID_STATUS, STATUS_02, 80'h0}, 2, CHK_MODEL, NO_RESULT));
    dir_rows.push_back(dir_row({RID_FULL, 88'h5a_0f_f0_3c_c3_00_fe_ff_01_80_7f}, 20,
                               CHK_MODEL, NO_RESULT));
    dir_rows.push_back(dir_row({RID_STATUS, STATUS_OTHER, 80'h0}, 2, CHK_NONE, NO_RESULT));
    dir_rows.push_back(dir_row({RID_STATUS, STATUS_OTHER, 80'h0}, 2, CHK_NONE, NO_RESULT));
    dir_rows.push_back(dir_row({RID_STATUS, STATUS_01, 80'h0}, 2, CHK_ONE, ACK_RESULT));

    foreach (dir_rows[i]) begin
      queue_packet(dir_rows[i].data, dir_rows[i].len, dir_rows[i].chk, dir_rows[i].res);
    end
    add_random_packets(RANDOM_ITEMS);

    @(posedge rst_ni);
    while (byte_stream_q.size() > 0) begin
      it = byte_stream_q.pop_front();
      if (byte_stream_q.size() < TAIL_ITEMS) calm_tail = 1;
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          @(negedge clk_i);
          in_valid_i = 1'b0;
        end
      end
      @(negedge clk_i);
      in_valid_i = 1'b1;
      rx_byte_i = it.data_byte;
      end_of_packet_i = it.eop;
      cur_item = it;
      do @(posedge clk_i); while (!in_ready_o);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
    stim_done = 1;
  end

  initial begin : receiver
    bit held_off;
    held_off = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && taken_cnt >= HOLD_OFF_AFTER) begin
        // long stall so the result queue fills and input backs up
        held_off = 1;
        out_ready_i = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    int n;
    pad_result_t got;
    pad_result_t want;
    if (!rst_ni) begin
      rx_count = '0;
      hs_phase = PH_WAIT01;
      subcmd_seq = '0;
      foreach (cap_bytes[i]) cap_bytes[i] = 8'h00;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {result_kind_o, buttons_o, left_x_o, left_y_o, right_x_o, right_y_o,
               l2_level_o, r2_level_o, code_o, arg_o, seq_no_o, last_o};
        taken_cnt++;
        if (pending_results_q.size() == 0) begin
          note_failure({"unexpected result: ", show(got)});
        end else begin
          want = pending_results_q.pop_front();
          if (got !== want) begin
            note_failure({"mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        n = translate_byte(rx_byte_i, end_of_packet_i);
        case (cur_item.chk)
          CHK_ONE: pending_results_q.push_back(cur_item.res);
          CHK_NONE: ;
          default: for (int i = 0; i < n; i++) pending_results_q.push_back(report_out[i]);
        endcase
      end
    end
  end

  initial begin : finisher
    int unsigned waited;
    fail_cnt = 0;
    taken_cnt = 0;
    wait (stim_done);
    waited = 0;
    while (pending_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results_q.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", pending_results_q.size()));
    end
    if (fail_cnt == 0) begin
      $display("[gamepad_report_translator] OK");
    end else begin
      $display("[gamepad_report_translator] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[gamepad_report_translator] ERROR");
    $finish;
  end

endmodule

// File: sim.f
hdl/grt_pkg.sv
hdl/grt_front.sv
hdl/grt_queue.sv
hdl/grt_back.sv
hdl/gamepad_report_translator.sv
tb/testbench.sv
